@@ hw/rtl/circle_rotated_rect_overlap_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef CIRCLE_ROTATED_RECT_OVERLAP_MACROS_SVH
`define CIRCLE_ROTATED_RECT_OVERLAP_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define CRRO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define CRRO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/crro_pkg.sv @@
package crro_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;

  // Binary angle is worked at 32 bits per turn inside the rotator.
  localparam int TURN_BITS = 32;
  localparam int TRIG_Q = 24;
  // cos/sin word: Q24 plus headroom for CORDIC growth and sign
  localparam int CW = 27;

  localparam int CORDIC_STEPS = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(10188014);

  localparam logic [TURN_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Pipeline stage positions
  localparam int S_IN = 0;
  localparam int S_CORD_LAST = S_IN + CORDIC_STAGES;
  localparam int S_MAP = S_CORD_LAST + 1;
  localparam int S_MUL = S_MAP + 1;
  localparam int S_SUM = S_MUL + 1;
  localparam int S_ABS = S_SUM + 1;
  localparam int S_CMP = S_ABS + 1;
  localparam int NUM_STAGES = S_CMP + 1;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef logic signed [CW-1:0] trig_t;
  typedef logic signed [TURN_BITS-1:0] turn_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [TURN_BITS-1:0] t;
  } cordic_t;

  // One rotation step; shifts floor toward minus infinity.
  function automatic cordic_t cordic_step(cordic_t a, int unsigned i);
    cordic_t r;
    trig_t xs;
    trig_t ys;
    xs = $signed(a.x) >>> i;
    ys = $signed(a.y) >>> i;
    if (!a.t[TURN_BITS-1]) begin
      r.x = $signed(a.x) - ys;
      r.y = $signed(a.y) + xs;
      r.t = $signed(a.t) - $signed(ATAN_TURNS[i]);
    end else begin
      r.x = $signed(a.x) + ys;
      r.y = $signed(a.y) - xs;
      r.t = $signed(a.t) + $signed(ATAN_TURNS[i]);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/circle_rotated_rect_overlap.sv @@
// Channel  Direction  Handshake          Beat contents
// in_      input      in_valid/in_stall  circle x, z, radius; rect x, z, angle, width, depth
// out_     output     out_valid/out_stall hit
//
// One beat enters per cycle while in_stall is low; a beat passes the input register, 12 CORDIC
// stages of two rotations each, quadrant map, multiply, sum, abs and compare.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output freezes only the full stages behind it; bubbles collapse,
// so input keeps being taken until every stage holds a beat.
`include "circle_rotated_rect_overlap_macros.svh"

module circle_rotated_rect_overlap #(
  parameter int COORD_BITS = crro_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = crro_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_circle_x,
  input  logic signed [COORD_BITS-1:0] in_circle_z,
  input  logic        [COORD_BITS-2:0] in_circle_radius,
  input  logic signed [COORD_BITS-1:0] in_rect_x,
  input  logic signed [COORD_BITS-1:0] in_rect_z,
  input  logic        [ANGLE_BITS-1:0] in_rect_angle,
  input  logic        [COORD_BITS-2:0] in_rect_width,
  input  logic        [COORD_BITS-2:0] in_rect_depth,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit
);

  localparam int NST = crro_pkg::NUM_STAGES;
  localparam int CW = crro_pkg::CW;
  localparam int TB = crro_pkg::TURN_BITS;
  localparam int DW = COORD_BITS + 1;        // center offsets, sizes
  localparam int PW = DW + CW;               // products
  localparam int LW = PW + 1;                // local offsets
  localparam int CMPW = LW + 1;

  // ---- stage control ----
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;
  logic in_acc;
  logic out_acc;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !en[0];
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign out_valid = v_r[NST-1];

  // ---- payload registers ----
  logic signed [DW-1:0] dx_r [0:crro_pkg::S_MAP];
  logic signed [DW-1:0] dz_r [0:crro_pkg::S_MAP];
  logic        [DW-1:0] tw_r [0:crro_pkg::S_ABS];
  logic        [DW-1:0] td_r [0:crro_pkg::S_ABS];
  logic [1:0]           q_r  [0:crro_pkg::S_CORD_LAST];
  crro_pkg::trig_t      x_r  [0:crro_pkg::S_CORD_LAST];
  crro_pkg::trig_t      y_r  [0:crro_pkg::S_CORD_LAST];
  crro_pkg::turn_t      t_r  [0:crro_pkg::S_CORD_LAST];

  // ---- input stage: offsets, grown sizes, quadrant split ----
  logic [TB-1:0] a32;
  logic [TB-1:0] a32_rnd;
  logic [1:0]    q_in;
  logic [TB-1:0] t_in;

  always_comb begin
    a32 = {in_rect_angle, {(TB - ANGLE_BITS){1'b0}}};
    a32_rnd = a32 + {3'b001, {(TB - 3){1'b0}}};
    q_in = a32_rnd[TB-1:TB-2];
    t_in = a32 - {q_in, {(TB - 2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_IN]) begin
      dx_r[0] <= DW'(in_circle_x) - DW'(in_rect_x);
      dz_r[0] <= DW'(in_circle_z) - DW'(in_rect_z);
      tw_r[0] <= {2'b00, in_rect_width} + {1'b0, in_circle_radius, 1'b0};
      td_r[0] <= {2'b00, in_rect_depth} + {1'b0, in_circle_radius, 1'b0};
      q_r[0]  <= q_in;
      x_r[0]  <= crro_pkg::CORDIC_GAIN;
      y_r[0]  <= '0;
      t_r[0]  <= $signed(t_in);
    end
  end

  // ---- CORDIC stages ----
  for (genvar j = 1; j <= crro_pkg::S_CORD_LAST; j++) begin : g_cordic
    crro_pkg::cordic_t st [crro_pkg::STEPS_PER_STAGE+1];

    always_comb begin
      st[0] = '{x: x_r[j-1], y: y_r[j-1], t: t_r[j-1]};
      for (int m = 0; m < crro_pkg::STEPS_PER_STAGE; m++) begin
        st[m+1] = crro_pkg::cordic_step(st[m],
                    (j - 1) * crro_pkg::STEPS_PER_STAGE + m);
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        x_r[j]  <= st[crro_pkg::STEPS_PER_STAGE].x;
        y_r[j]  <= st[crro_pkg::STEPS_PER_STAGE].y;
        t_r[j]  <= st[crro_pkg::STEPS_PER_STAGE].t;
        q_r[j]  <= q_r[j-1];
        dx_r[j] <= dx_r[j-1];
        dz_r[j] <= dz_r[j-1];
        tw_r[j] <= tw_r[j-1];
        td_r[j] <= td_r[j-1];
      end
    end
  end

  // ---- quadrant map ----
  crro_pkg::trig_t cos_nxt;
  crro_pkg::trig_t sin_nxt;
  crro_pkg::trig_t cos_r;
  crro_pkg::trig_t sin_r;
  crro_pkg::trig_t xl;
  crro_pkg::trig_t yl;

  always_comb begin
    xl = x_r[crro_pkg::S_CORD_LAST];
    yl = y_r[crro_pkg::S_CORD_LAST];
    unique case (crro_pkg::quad_t'(q_r[crro_pkg::S_CORD_LAST]))
      crro_pkg::QUAD_0: begin
        cos_nxt = xl;
        sin_nxt = yl;
      end
      crro_pkg::QUAD_1: begin
        cos_nxt = -yl;
        sin_nxt = xl;
      end
      crro_pkg::QUAD_2: begin
        cos_nxt = -xl;
        sin_nxt = -yl;
      end
      default: begin
        cos_nxt = yl;
        sin_nxt = -xl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_MAP]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      dx_r[crro_pkg::S_MAP] <= dx_r[crro_pkg::S_CORD_LAST];
      dz_r[crro_pkg::S_MAP] <= dz_r[crro_pkg::S_CORD_LAST];
      tw_r[crro_pkg::S_MAP] <= tw_r[crro_pkg::S_CORD_LAST];
      td_r[crro_pkg::S_MAP] <= td_r[crro_pkg::S_CORD_LAST];
    end
  end

  // ---- multiply ----
  logic signed [PW-1:0] p_xc_r;
  logic signed [PW-1:0] p_zs_r;
  logic signed [PW-1:0] p_zc_r;
  logic signed [PW-1:0] p_xs_r;

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_MUL]) begin
      p_xc_r <= PW'(dx_r[crro_pkg::S_MAP]) * PW'(cos_r);
      p_zs_r <= PW'(dz_r[crro_pkg::S_MAP]) * PW'(sin_r);
      p_zc_r <= PW'(dz_r[crro_pkg::S_MAP]) * PW'(cos_r);
      p_xs_r <= PW'(dx_r[crro_pkg::S_MAP]) * PW'(sin_r);
      tw_r[crro_pkg::S_MUL] <= tw_r[crro_pkg::S_MAP];
      td_r[crro_pkg::S_MUL] <= td_r[crro_pkg::S_MAP];
    end
  end

  // ---- rotate into the rectangle frame ----
  logic signed [LW-1:0] lx_r;
  logic signed [LW-1:0] lz_r;

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_SUM]) begin
      lx_r <= LW'(p_xc_r) - LW'(p_zs_r);
      lz_r <= LW'(p_zc_r) + LW'(p_xs_r);
      tw_r[crro_pkg::S_SUM] <= tw_r[crro_pkg::S_MUL];
      td_r[crro_pkg::S_SUM] <= td_r[crro_pkg::S_MUL];
    end
  end

  // ---- magnitude ----
  logic [LW-1:0] ax_r;
  logic [LW-1:0] az_r;

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_ABS]) begin
      ax_r <= lx_r[LW-1] ? LW'(-lx_r) : LW'(lx_r);
      az_r <= lz_r[LW-1] ? LW'(-lz_r) : LW'(lz_r);
      tw_r[crro_pkg::S_ABS] <= tw_r[crro_pkg::S_SUM];
      td_r[crro_pkg::S_ABS] <= td_r[crro_pkg::S_SUM];
    end
  end

  // ---- strict compare against grown half sides (both scaled by 2) ----
  logic [CMPW-1:0] lim_x;
  logic [CMPW-1:0] lim_z;
  logic            hit_nxt;
  logic            hit_r;

  always_comb begin
    lim_x = CMPW'({tw_r[crro_pkg::S_ABS], {crro_pkg::TRIG_Q{1'b0}}});
    lim_z = CMPW'({td_r[crro_pkg::S_ABS], {crro_pkg::TRIG_Q{1'b0}}});
    hit_nxt = ({ax_r, 1'b0} < lim_x) && ({az_r, 1'b0} < lim_z);
  end

  always_ff @(posedge clk) begin
    if (en[crro_pkg::S_CMP]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_hit = hit_r;

  // ---- checks ----
  `CRRO_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, &v_r,
    "input stalled with a free stage")
  `CRRO_ASSERT_IMPL(a_occupancy, clk, rst_n, $past(rst_n),
    $countones(v_r) == $past($countones(v_r)) + $past(32'(in_acc)) - $past(32'(out_acc)),
    "beat lost or duplicated in pipeline")
  `CRRO_ASSERT_NEXT(a_zero_size, clk, rst_n,
    v_r[crro_pkg::S_ABS] && en[crro_pkg::S_CMP] && (tw_r[crro_pkg::S_ABS] == '0),
    !out_hit, "hit reported with zero width and radius")

endmodule
